/* hw/rtl/agp_pkg.sv */
// Shared constants, control structs and the exp2 root table for the Asian path payoff unit.
package agp_pkg;

  localparam int FracBits = 24;
  localparam int LogSumW  = 48;
  localparam int PriceW   = 32;
  localparam int CoefW    = 32;
  localparam int SampleW  = 16;
  localparam int SumW     = 64;
  localparam int CountW   = 32;
  localparam int StepsW   = 11;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int IterW    = 6;
  localparam int MW       = 36;
  localparam int DivIters = LogSumW;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgInitPrice = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDrift     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgVol       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStrike    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCall      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSteps     = 3'd5;

  // Register reset values
  localparam logic [PriceW-1:0] InitPriceRst = 32'd6553600;
  localparam logic [CoefW-1:0]  DriftRst     = 32'd536871;
  localparam logic [CoefW-1:0]  VolRst       = 32'd42949673;
  localparam logic [PriceW-1:0] StrikeRst    = 32'd6553600;
  localparam logic              CallRst      = 1'b1;
  localparam logic [StepsW-1:0] StepsRst     = 11'd100;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             grow;
    logic             mul;
    logic             price;
    logic             log_norm;
    logic             log_iter;
    logic             log_add;
    logic             div_init;
    logic             div_iter;
    logic             exp_init;
    logic             exp_iter;
    logic             pay;
    logic             commit;
    logic [IterW-1:0] iter;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_step;
    logic out_free;
  } status_t;

  typedef logic [FracBits-1:0][31:0] root_tab_t;

  // Integer square root, one result bit per pass
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    rem  = n;
    root = 64'd0;
    b    = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Successive square roots of 2.0 in Q1.31, entry k-1 holds 2^(2^-k)
  function automatic root_tab_t root_table();
    root_tab_t   t;
    logic [63:0] r;
    r = 64'h1_0000_0000;
    for (int k = 0; k < FracBits; k++) begin
      r    = isqrt64(r << 31);
      t[k] = r[31:0];
    end
    return t;
  endfunction

endpackage

/* hw/rtl/agp_in_if.sv */
// Sample channel: one normal draw per beat.
interface agp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [agp_pkg::SampleW-1:0]  normal_sample;

  modport source (output valid, output normal_sample, input ready);
  modport sink   (input valid, input normal_sample, output ready);
endinterface

/* hw/rtl/agp_out_if.sv */
// Result channel: payoff of a finished path with running totals.
interface agp_out_if;
  logic                         valid;
  logic                         ready;
  logic [agp_pkg::PriceW-1:0]   path_payoff;
  logic [agp_pkg::SumW-1:0]     payoff_sum;
  logic [agp_pkg::CountW-1:0]   path_count;

  modport source (output valid, output path_payoff, output payoff_sum, output path_count,
                  input ready);
  modport sink   (input valid, input path_payoff, input payoff_sum, input path_count,
                  output ready);
endinterface

/* hw/rtl/agp_ctrl.sv */
// Sequencer for the step, divide and exp2 phases of the path engine.
module agp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  agp_pkg::status_t status_i,
  output agp_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StGrow  = 4'd1;
  localparam logic [3:0] StMul   = 4'd2;
  localparam logic [3:0] StPrice = 4'd3;
  localparam logic [3:0] StLogN  = 4'd4;
  localparam logic [3:0] StLog   = 4'd5;
  localparam logic [3:0] StAdd   = 4'd6;
  localparam logic [3:0] StDivI  = 4'd7;
  localparam logic [3:0] StDiv   = 4'd8;
  localparam logic [3:0] StExpI  = 4'd9;
  localparam logic [3:0] StExp   = 4'd10;
  localparam logic [3:0] StPay   = 4'd11;
  localparam logic [3:0] StOut   = 4'd12;

  localparam logic [agp_pkg::IterW-1:0] FracLast =
    agp_pkg::IterW'(agp_pkg::FracBits - 1);
  localparam logic [agp_pkg::IterW-1:0] DivLast =
    agp_pkg::IterW'(agp_pkg::DivIters - 1);

  logic [3:0]                state_q, state_d;
  logic [agp_pkg::IterW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and command strobes
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.iter = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StGrow;
        end
      end
      StGrow: begin
        cmd_o.grow = 1'b1;
        state_d    = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StPrice;
      end
      StPrice: begin
        cmd_o.price = 1'b1;
        state_d     = StLogN;
      end
      StLogN: begin
        cmd_o.log_norm = 1'b1;
        cnt_d          = '0;
        state_d        = StLog;
      end
      StLog: begin
        cmd_o.log_iter = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == FracLast) state_d = StAdd;
      end
      StAdd: begin
        cmd_o.log_add = 1'b1;
        state_d       = status_i.last_step ? StDivI : StIdle;
      end
      StDivI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_iter = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLast) state_d = StExpI;
      end
      StExpI: begin
        cmd_o.exp_init = 1'b1;
        cnt_d          = '0;
        state_d        = StExp;
      end
      StExp: begin
        cmd_o.exp_iter = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == FracLast) state_d = StPay;
      end
      StPay: begin
        cmd_o.pay = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* hw/rtl/agp_datapath.sv */
// Price, log2, divider, exp2 and payoff registers of the path engine.
module agp_datapath #(
  parameter int MAX_STEPS = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [agp_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [agp_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  logic signed [agp_pkg::SampleW-1:0]   sample_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [agp_pkg::PriceW-1:0]           out_payoff_o,
  output logic [agp_pkg::SumW-1:0]             out_sum_o,
  output logic [agp_pkg::CountW-1:0]           out_count_o,
  input  agp_pkg::cmd_t                        cmd_i,
  output agp_pkg::status_t                     status_o
);

  localparam int CntW = $clog2(MAX_STEPS + 1);
  localparam int FB   = agp_pkg::FracBits;
  localparam int LW   = agp_pkg::LogSumW;
  localparam int MW   = agp_pkg::MW;
  localparam agp_pkg::root_tab_t RootTab = agp_pkg::root_table();

  // Configuration registers
  logic [31:0]                        init_price_q;
  logic signed [31:0]                 drift_q;
  logic signed [31:0]                 vol_q;
  logic [31:0]                        strike_q;
  logic                               call_q;
  logic [agp_pkg::StepsW-1:0]         steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_price_q <= agp_pkg::InitPriceRst;
      drift_q      <= agp_pkg::DriftRst;
      vol_q        <= agp_pkg::VolRst;
      strike_q     <= agp_pkg::StrikeRst;
      call_q       <= agp_pkg::CallRst;
      steps_q      <= agp_pkg::StepsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        agp_pkg::CfgInitPrice: init_price_q <= cfg_wdata_i;
        agp_pkg::CfgDrift:     drift_q      <= cfg_wdata_i;
        agp_pkg::CfgVol:       vol_q        <= cfg_wdata_i;
        agp_pkg::CfgStrike:    strike_q     <= cfg_wdata_i;
        agp_pkg::CfgCall:      call_q       <= cfg_wdata_i[0];
        agp_pkg::CfgSteps:     steps_q      <= cfg_wdata_i[agp_pkg::StepsW-1:0];
        default: ;
      endcase
    end
  end

  // Effective path length
  logic [CntW-1:0] n_eff;
  always_comb begin
    if (steps_q == '0) n_eff = CntW'(1);
    else if (32'(steps_q) > 32'(MAX_STEPS)) n_eff = CntW'(MAX_STEPS);
    else n_eff = CntW'(steps_q);
  end

  logic [CntW-1:0]        step_idx_q;
  logic signed [LW-1:0]   log_sum_q;
  logic [CntW:0]          step_next;
  logic                   last_step;

  assign step_next = {1'b0, step_idx_q} + 1'b1;
  assign last_step = step_next >= {1'b0, n_eff};

  // Growth factor m = 1 + drift + vol*z in Q.30
  logic signed [15:0]     z_q;
  logic signed [47:0]     vz;
  logic signed [47:0]     vzs;
  logic signed [MW-1:0]   m_d, m_q;
  logic [31:0]            s_q;

  assign vz  = vol_q * z_q;
  assign vzs = vz >>> 12;
  assign m_d = MW'(vzs) + MW'(drift_q) + 36'sd1073741824;

  // Price product, split on the Q.30 point
  logic [61:0] plo_q;
  logic [36:0] phi_q;
  logic        mneg_q;
  logic [37:0] res;
  logic [31:0] price_d, path_price_q;

  assign res = {1'b0, phi_q} + 38'(plo_q[61:30]);
  always_comb begin
    if (mneg_q) price_d = 32'd1;
    else if (res > 38'h0_FFFF_FFFF) price_d = 32'hFFFF_FFFF;
    else if (res == '0) price_d = 32'd1;
    else price_d = res[31:0];
  end

  // Leading one of the price
  logic [4:0] lead;
  always_comb begin
    lead = '0;
    for (int b = 0; b < 32; b++) begin
      if (path_price_q[b]) lead = 5'(b);
    end
  end

  // Log2 mantissa squaring
  logic [31:0]        y_q;
  logic [63:0]        ysq;
  logic [32:0]        y2;
  logic [FB-1:0]      frac_q;
  logic signed [5:0]  lp_q;
  logic [LW-1:0]      logv;

  assign ysq  = y_q * y_q;
  assign y2   = ysq[63:31];
  assign logv = {{(LW - FB - 6){lp_q[5]}}, lp_q, frac_q};

  // Divider of the log sum by the path length
  logic              neg_q;
  logic [LW-1:0]     dvd_q;
  logic [CntW-1:0]   rem_q;
  logic [CntW:0]     trial;
  logic              qbit;
  logic [LW-1:0]     quo_adj;
  logic [LW-1:0]     a_d;

  assign trial   = {rem_q, dvd_q[LW-1]};
  assign qbit    = trial >= {1'b0, n_eff};
  assign quo_adj = dvd_q + LW'(rem_q != '0);
  assign a_d     = neg_q ? (~quo_adj + 1'b1) : dvd_q;

  // exp2 of the average
  logic [FB-1:0]          f_q;
  logic signed [LW-FB-1:0] i_q;
  logic [31:0]            acc_q;
  logic [63:0]            accp;
  logic [31:0]            root;
  logic signed [LW-FB-1:0] sh_full;
  logic [31:0]            g;
  logic [31:0]            pay_q;
  logic [31:0]            pay_d;

  assign root    = RootTab[cmd_i.iter[4:0]];
  assign accp    = acc_q * root;
  assign sh_full = (LW-FB)'(15) - i_q;

  always_comb begin
    if (i_q > (LW-FB)'(15)) g = 32'hFFFF_FFFF;
    else if (sh_full > (LW-FB)'(31)) g = '0;
    else g = acc_q >> sh_full[4:0];
    if (call_q) pay_d = (g > strike_q) ? g - strike_q : '0;
    else pay_d = (g < strike_q) ? strike_q - g : '0;
  end

  // Totals
  logic [agp_pkg::SumW-1:0]   total_q, total_d;
  logic [agp_pkg::SumW:0]     total_sum;
  logic [agp_pkg::CountW-1:0] count_q, count_d;
  logic                       out_valid_q;

  assign total_sum = {1'b0, total_q} + 65'(pay_q);
  assign total_d   = total_sum[agp_pkg::SumW] ? '1 : total_sum[agp_pkg::SumW-1:0];
  assign count_d   = (count_q == '1) ? count_q : count_q + 1'b1;

  // Path state and totals, reset cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_idx_q  <= '0;
      log_sum_q   <= '0;
      total_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.log_add) begin
        log_sum_q <= log_sum_q + $signed(logv);
        if (!last_step) step_idx_q <= step_next[CntW-1:0];
      end
      if (cmd_i.commit) begin
        step_idx_q  <= '0;
        log_sum_q   <= '0;
        total_q     <= total_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) z_q <= sample_i;
    if (cmd_i.grow) begin
      m_q <= m_d;
      s_q <= (step_idx_q == '0) ? init_price_q : path_price_q;
    end
    if (cmd_i.mul) begin
      mneg_q <= m_q <= 36'sd0;
      plo_q  <= s_q * m_q[29:0];
      phi_q  <= s_q * m_q[34:30];
    end
    if (cmd_i.price) path_price_q <= price_d;
    if (cmd_i.log_norm) begin
      y_q    <= path_price_q << (5'd31 - lead);
      lp_q   <= $signed({1'b0, lead}) - 6'sd16;
      frac_q <= '0;
    end
    if (cmd_i.log_iter) begin
      if (y2[32]) begin
        y_q    <= y2[32:1];
        frac_q <= {frac_q[FB-2:0], 1'b1};
      end else begin
        y_q    <= y2[31:0];
        frac_q <= {frac_q[FB-2:0], 1'b0};
      end
    end
    if (cmd_i.div_init) begin
      neg_q <= log_sum_q[LW-1];
      dvd_q <= log_sum_q[LW-1] ? LW'(-log_sum_q) : LW'(log_sum_q);
      rem_q <= '0;
    end
    if (cmd_i.div_iter) begin
      rem_q <= qbit ? CntW'(trial - {1'b0, n_eff}) : trial[CntW-1:0];
      dvd_q <= {dvd_q[LW-2:0], qbit};
    end
    if (cmd_i.exp_init) begin
      f_q   <= a_d[FB-1:0];
      i_q   <= $signed(a_d[LW-1:FB]);
      acc_q <= 32'h8000_0000;
    end
    if (cmd_i.exp_iter) begin
      if (f_q[FB-1]) acc_q <= accp[62:31];
      f_q <= {f_q[FB-2:0], 1'b0};
    end
    if (cmd_i.pay) pay_q <= pay_d;
    if (cmd_i.commit) begin
      out_payoff_o <= pay_q;
      out_sum_o    <= total_d;
      out_count_o  <= count_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.last_step = last_step;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

/* hw/rtl/asian_geometric_path_payoff_unit.sv */
// Top level of the geometric Asian option path payoff unit.
//
//   port      dir  beat contents
//   sample_i  in   normal_sample, Q4.12 draw for one time step
//   result_o  out  path_payoff, payoff_sum, path_count at each path end
//   cfg_*     in   register write: cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// Each sample passes accept, the grow, multiply and price steps for the price, a normalise,
// the log2 squaring loop (one mantissa bit a cycle) and an add of the log.
// The sample that ends a path then runs the bit-serial divide by the path length,
// the set-up and products of the exp2 roots, the payoff and the hand-over to the
// result register.
// A result waiting on result_o stalls only the next path end.
// Reset is asynchronous, active low, and restores all register defaults.
module asian_geometric_path_payoff_unit #(
  parameter int MAX_STEPS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [agp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [agp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  agp_in_if.sink                        sample_i,
  agp_out_if.source                     result_o
);

  agp_pkg::cmd_t    cmd;
  agp_pkg::status_t status;
  logic             in_ready;

  agp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  agp_datapath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (sample_i.normal_sample),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .out_payoff_o (result_o.path_payoff),
    .out_sum_o    (result_o.payoff_sum),
    .out_count_o  (result_o.path_count),
    .cmd_i        (cmd),
    .status_o     (status)
  );

  assign sample_i.ready = in_ready;

`ifndef SYNTHESIS
  // A committed path shows a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> result_o.valid)
    else $error("commit did not raise result valid");

  // A shown result always counts at least one path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.path_count != '0)
    else $error("result with zero path count");

  // The running sum never falls below the payoff it includes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.payoff_sum >= 64'(result_o.path_payoff))
    else $error("payoff sum below path payoff");

  // One sample at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> !sample_i.ready)
    else $error("sample accepted while busy");
`endif

endmodule

/* verif/asian_geometric_path_payoff_unit_tb.sv */
// Self-checking bench for the geometric Asian option path payoff unit.
`timescale 1ns / 1ps

module asian_geometric_path_payoff_unit_tb;

  localparam int MaxSteps  = 1024;
  localparam int WatchLim  = 200000;
  localparam logic [agp_pkg::CfgIdxW-1:0] CfgUnused = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [agp_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [agp_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  agp_in_if  smp_if ();
  agp_out_if res_if ();

  asian_geometric_path_payoff_unit #(.MAX_STEPS(MaxSteps)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .sample_i(smp_if.sink), .result_o(res_if.source)
  );

  always #4 clk_i = ~clk_i;

  typedef struct packed {
    logic [agp_pkg::PriceW-1:0] payoff;
    logic [agp_pkg::SumW-1:0]   total;
    logic [agp_pkg::CountW-1:0] count;
  } payoff_beat_t;

  // Directed stimulus row; chk set when the result is typed in
  typedef struct {
    logic [15:0]  z;
    logic         chk;
    payoff_beat_t res;
  } dir_row_t;

  // Shadow registers and path state
  logic [31:0] s0_q, strike_q;
  logic signed [31:0] drift_q, vol_q;
  logic call_q;
  logic [10:0] steps_q;
  logic [31:0] price_q;
  longint log_sum_q;
  int unsigned step_q;
  logic [63:0] total_q;
  logic [31:0] count_q;

  payoff_beat_t payoff_q[$];
  dir_row_t dir_rows[$];
  payoff_beat_t nb;
  int errors = 0;
  int watch = 0;

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic logic [63:0] sqrt_u64(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] grow_price(logic [31:0] s, longint z);
    longint m;
    logic [63:0] res;
    m = 64'sd1073741824 + longint'(drift_q) + fdiv(longint'(vol_q) * z, 4096);
    if (m <= 0) return 32'd1;
    res = 64'(s) * 64'(m >>> 30) + ((64'(s) * 64'(m & 64'h3FFF_FFFF)) >> 30);
    if (res > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    if (res == 0) return 32'd1;
    return res[31:0];
  endfunction

  function automatic longint log2_q24(logic [31:0] s);
    int p;
    logic [63:0] y;
    longint fr;
    p = 31;
    fr = 0;
    while (p > 0 && !s[p]) p--;
    y = 64'(s) << (31 - p);
    for (int k = 0; k < agp_pkg::FracBits; k++) begin
      y = (y * y) >> 31;
      fr <<= 1;
      if (y >= 64'h1_0000_0000) begin
        fr |= 1;
        y >>= 1;
      end
    end
    return longint'(p - 16) * 64'sd16777216 + fr;
  endfunction

  function automatic logic [31:0] exp2_avg(longint a);
    longint i, sh;
    logic [63:0] f, r, acc, g;
    i = fdiv(a, 64'sd16777216);
    f = a - i * 64'sd16777216;
    r = 64'h1_0000_0000;
    acc = 64'h8000_0000;
    for (int k = 1; k <= agp_pkg::FracBits; k++) begin
      r = sqrt_u64(r << 31);
      if (f[agp_pkg::FracBits-k]) acc = (acc * r) >> 31;
    end
    sh = 15 - i;
    if (sh > 63) return 32'd0;
    if (sh < 0) return 32'hFFFF_FFFF;
    g = acc >> sh;
    if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
    return g[31:0];
  endfunction

  // Advance one step; returns 1 and the beat when the path completes
  function automatic bit path_step(logic [15:0] zb, output payoff_beat_t b);
    int unsigned n;
    longint z;
    logic [31:0] g, pay;
    z = longint'($signed(zb));
    n = steps_q;
    b = '0;
    if (n < 1) n = 1;
    if (n > MaxSteps) n = MaxSteps;
    price_q = grow_price((step_q == 0) ? s0_q : price_q, z);
    log_sum_q += log2_q24(price_q);
    if (step_q + 1 < n) begin
      step_q++;
      return 0;
    end
    g = exp2_avg(fdiv(log_sum_q, longint'(n)));
    if (call_q) pay = (g > strike_q) ? g - strike_q : 0;
    else pay = (g < strike_q) ? strike_q - g : 0;
    if (total_q > 64'hFFFF_FFFF_FFFF_FFFF - 64'(pay)) total_q = '1;
    else total_q += 64'(pay);
    if (count_q != '1) count_q++;
    price_q = s0_q;
    log_sum_q = 0;
    step_q = 0;
    b.payoff = pay;
    b.total = total_q;
    b.count = count_q;
    return 1;
  endfunction

  // Register write, only once the block holds nothing in flight
  task automatic reg_write(logic [agp_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    while (payoff_q.size() != 0 || !smp_if.ready) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      agp_pkg::CfgInitPrice: s0_q = val;
      agp_pkg::CfgDrift:     drift_q = val;
      agp_pkg::CfgVol:       vol_q = val;
      agp_pkg::CfgStrike:    strike_q = val;
      agp_pkg::CfgCall:      call_q = val[0];
      agp_pkg::CfgSteps:     steps_q = val[10:0];
      default: ;
    endcase
  endtask

  // Let the block drain, including a trailing non-result sample
  task automatic settle();
    while (payoff_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic gap(int unsigned longest);
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, longest) : $urandom_range(0, 2);
    repeat (n) @(negedge clk_i);
  endtask

  function automatic void payoff_queue_push(payoff_beat_t b);
    payoff_q.insert(payoff_q.size(), b);
  endfunction

  function automatic void add_row(logic [15:0] z, logic chk, payoff_beat_t res);
    dir_row_t r;
    r.z = z;
    r.chk = chk;
    r.res = res;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Drive one sample beat; predict at acceptance
  task automatic send_sample(logic [15:0] z, bit chk, payoff_beat_t want);
    payoff_beat_t b;
    @(negedge clk_i);
    smp_if.valid <= 1'b1;
    smp_if.normal_sample <= z;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    if (path_step(z, b)) begin
      if (chk && b != want) begin
        $display("%0t predictor row mismatch exp %h got %h", $time, want, b);
        errors++;
      end
      payoff_queue_push(b);
    end
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    smp_if.normal_sample <= 16'($urandom());
  endtask

  // Result checking at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (payoff_q.size() == 0) begin
          $display("%0t unexpected result beat %h", $time,
                   {res_if.path_payoff, res_if.payoff_sum, res_if.path_count});
          errors++;
        end else begin
          payoff_beat_t e;
          e = payoff_q.pop_front();
          if (res_if.path_payoff !== e.payoff) begin
            $display("%0t path_payoff exp %h got %h", $time, e.payoff, res_if.path_payoff);
            errors++;
          end
          if (res_if.payoff_sum !== e.total) begin
            $display("%0t payoff_sum exp %h got %h", $time, e.total, res_if.payoff_sum);
            errors++;
          end
          if (res_if.path_count !== e.count) begin
            $display("%0t path_count exp %h got %h", $time, e.count, res_if.path_count);
            errors++;
          end
        end
      end
    end
  end

  // Sink stalls
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 2))
          @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
    end
  end

  // Watchdog on accepted beats
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || cfg_we_i)
      watch <= 0;
    else
      watch <= watch + 1;
    if (watch >= WatchLim) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned nlen;
    smp_if.valid = 1'b0;
    smp_if.normal_sample = '0;
    s0_q = agp_pkg::InitPriceRst; drift_q = agp_pkg::DriftRst; vol_q = agp_pkg::VolRst;
    strike_q = agp_pkg::StrikeRst; call_q = agp_pkg::CallRst; steps_q = agp_pkg::StepsRst;
    price_q = s0_q; log_sum_q = 0; step_q = 0; total_q = 0; count_q = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: one-step paths, zero drift/vol keeps the price at S0
    reg_write(agp_pkg::CfgSteps, 32'd1);
    reg_write(agp_pkg::CfgDrift, 32'd0);
    reg_write(agp_pkg::CfgVol, 32'd0);
    reg_write(agp_pkg::CfgStrike, 32'd6553600);
    reg_write(agp_pkg::CfgInitPrice, 32'd6553600);
    nb = '{payoff: 32'd0, total: 64'd0, count: 32'd1};
    add_row(16'h0000, 1'b1, nb);
    nb = '{payoff: 32'd0, total: 64'd0, count: 32'd2};
    add_row(16'h7FFF, 1'b1, nb);
    add_row(16'h8000, 1'b0, nb);
    add_row(16'hFFFF, 1'b0, nb);
    add_row(16'h0001, 1'b0, nb);
    foreach (dir_rows[i]) send_sample(dir_rows[i].z, dir_rows[i].chk, dir_rows[i].res);
    settle();

    // Directed: extremes of registers, put, zero price, growth clamp
    reg_write(agp_pkg::CfgVol, 32'h7FFF_FFFF);
    reg_write(agp_pkg::CfgDrift, 32'h8000_0000);
    reg_write(agp_pkg::CfgCall, 32'd0);
    reg_write(agp_pkg::CfgInitPrice, 32'd0);
    reg_write(agp_pkg::CfgSteps, 32'd0);
    send_sample(16'h8000, 0, nb);
    send_sample(16'h7FFF, 0, nb);
    reg_write(agp_pkg::CfgInitPrice, 32'hFFFF_FFFF);
    reg_write(agp_pkg::CfgDrift, 32'h7FFF_FFFF);
    reg_write(agp_pkg::CfgStrike, 32'd0);
    reg_write(agp_pkg::CfgCall, 32'd1);
    reg_write(agp_pkg::CfgSteps, 32'd3);
    for (int k = 0; k < 6; k++) send_sample(16'($urandom()), 0, nb);
    reg_write(agp_pkg::CfgStrike, 32'hFFFF_FFFF);
    reg_write(agp_pkg::CfgVol, 32'h8000_0000);
    reg_write(agp_pkg::CfgCall, 32'd0);
    for (int k = 0; k < 3; k++) send_sample(16'h7FFF, 0, nb);
    settle();
    // Steps above the maximum, then lowered mid-path, and unused index
    reg_write(agp_pkg::CfgSteps, 32'h7FF);
    reg_write(CfgUnused, 32'hDEAD_BEEF);
    reg_write(agp_pkg::CfgVol, 32'd42949673);
    reg_write(agp_pkg::CfgDrift, 32'd536871);
    reg_write(agp_pkg::CfgInitPrice, 32'd6553600);
    reg_write(agp_pkg::CfgStrike, 32'd6553600);
    for (int k = 0; k < 5; k++) send_sample(16'($urandom()), 0, nb);
    settle();
    reg_write(agp_pkg::CfgSteps, 32'd2);
    reg_write(agp_pkg::CfgInitPrice, 32'd3276800);
    send_sample(16'h1000, 0, nb);
    settle();

    // Random phases with new settings
    for (int ph = 0; ph < 12; ph++) begin
      reg_write(agp_pkg::CfgInitPrice,
                ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1 << 16, 1 << 24));
      reg_write(agp_pkg::CfgDrift,
                ($urandom_range(0, 7) == 0) ? $urandom() :
                                              $urandom_range(0, 1 << 22) - (1 << 21));
      reg_write(agp_pkg::CfgVol,
                ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 1 << 27));
      reg_write(agp_pkg::CfgStrike,
                ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1 << 16, 1 << 24));
      reg_write(agp_pkg::CfgCall, $urandom_range(0, 1));
      nlen = (ph == 11) ? MaxSteps : $urandom_range(1, 8);
      reg_write(agp_pkg::CfgSteps, nlen);
      for (int k = 0; k < ((ph == 11) ? 1100 : 70); k++) begin
        gap(40);
        send_sample(16'($urandom()), 0, nb);
        if (ph == 5 && k == 30) begin
          while (payoff_q.size() != 0) @(posedge clk_i);
        end
      end
      settle();
    end

    settle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/agp_pkg.sv
hw/rtl/agp_in_if.sv
hw/rtl/agp_out_if.sv
hw/rtl/agp_ctrl.sv
hw/rtl/agp_datapath.sv
hw/rtl/asian_geometric_path_payoff_unit.sv
verif/asian_geometric_path_payoff_unit_tb.sv
